[sv/three_axis_fir_lowpass_core_macros.svh]
// assertion helpers for the three-axis low-pass filter core
// each check samples on clk and is disabled while rst_n is low
`ifndef THREE_AXIS_FIR_LOWPASS_CORE_MACROS_SVH
`define THREE_AXIS_FIR_LOWPASS_CORE_MACROS_SVH

`ifndef ASSERT_OFF

`define TAFIR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tafir check failed");

`define TAFIR_NEVER(lbl, expr) \
  `TAFIR_ASSERT(lbl, !(expr))

`else

`define TAFIR_ASSERT(lbl, prop)

`define TAFIR_NEVER(lbl, expr)

`endif

`endif

[sv/tafir_pkg.sv]
package tafir_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int DIGIT_W    = 8;
  localparam int COEF_MAX_W = 24;
  localparam int TABLE_LEN  = 201;
  localparam int HALF_LEN   = 101;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered_x;
    logic signed [SAMPLE_W-1:0] filtered_y;
    logic signed [SAMPLE_W-1:0] filtered_z;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRIME,
    ST_MAC,
    ST_ACC,
    ST_ROUND,
    ST_SAT
  } fir_state_t;

  // q1.15 taps from the outer tap to the center tap, mirrored about the center
  localparam logic signed [15:0] HALF_COEF [HALF_LEN] = '{
    -16'sd2, -16'sd7, -16'sd8, -16'sd5, 16'sd1, 16'sd7, 16'sd10, 16'sd7, 16'sd0, -16'sd8,
    -16'sd12, -16'sd9, -16'sd1, 16'sd8, 16'sd15, 16'sd13, 16'sd4, -16'sd9, -16'sd18,
    -16'sd19,
    -16'sd8, 16'sd8, 16'sd22, 16'sd25, 16'sd14, -16'sd7, -16'sd26, -16'sd33, -16'sd22,
    16'sd3,
    16'sd30, 16'sd42, 16'sd32, 16'sd2, -16'sd33, -16'sd53, -16'sd45, -16'sd11, 16'sd33,
    16'sd64,
    16'sd61, 16'sd23, -16'sd32, -16'sd74, -16'sd79, -16'sd39, 16'sd27, 16'sd84, 16'sd100,
    16'sd60,
    -16'sd17, -16'sd93, -16'sd123, -16'sd87, 16'sd2, 16'sd98, 16'sd148, 16'sd119, 16'sd20,
    -16'sd100,
    -16'sd175, -16'sd158, -16'sd50, 16'sd96, 16'sd202, 16'sd204, 16'sd91, -16'sd84,
    -16'sd229, -16'sd258,
    -16'sd144, 16'sd63, 16'sd255, 16'sd323, 16'sd214, -16'sd28, -16'sd280, -16'sd402,
    -16'sd308, -16'sd27,
    16'sd303, 16'sd501, 16'sd438, 16'sd114, -16'sd322, -16'sd637, -16'sd631, -16'sd256,
    16'sd338, 16'sd848,
    16'sd960, 16'sd521, -16'sd350, -16'sd1262, -16'sd1689, -16'sd1194, 16'sd357, 16'sd2695,
    16'sd5202, 16'sd7120,
    16'sd7838
  };

  // tap coefficient scaled to cw bits; taps past the table are zero
  function automatic logic signed [COEF_MAX_W-1:0] coef_at(input int idx, input int cw);
    int c;
    int s;
    if (idx < 0 || idx >= TABLE_LEN) begin
      return '0;
    end
    c = int'(HALF_COEF[(idx < HALF_LEN) ? idx : (TABLE_LEN - 1 - idx)]);
    if (cw >= 16) begin
      c = c <<< (cw - 16);
    end else begin
      // round half up
      s = 16 - cw;
      c = (c + (1 <<< (s - 1))) >>> s;
    end
    return COEF_MAX_W'(c);
  endfunction

endpackage

[sv/three_axis_fir_lowpass_core.sv]
// three-axis low-pass fir core
//
// input channel: in_valid / in_stall carry one word of three signed 16-bit axis
// samples; a word is taken when in_valid is high and in_stall is low
// output channel: out_valid / out_stall carry one word of three filtered values;
// the output register holds its word until the receiver drops out_stall
// cfg channel: cfg_valid / cfg_ready (always ready) writes the output enable bit
//
// each word is shifted into a circular history memory and every tap is run
// through a digit-serial multiply, one 8-bit coefficient digit per cycle, with
// the three axes in parallel lanes; after a word is taken the run passes the
// prime, mac, acc, round and sat states, and out_valid rises from sat
// no new word is taken before the run is done: in_stall stays high while the
// filter runs or a finished result is blocked behind a stalled output register
// with output enable low the history still updates and nothing is sent
// reset (rst_n, synchronous) clears the history valid bits, so the whole
// history reads as zero, and clears output enable

`include "three_axis_fir_lowpass_core_macros.svh"

module three_axis_fir_lowpass_core
  import tafir_pkg::*;
#(
  parameter int TAPS       = 201,
  parameter int COEF_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  localparam int ND = (COEF_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int CP = ND * DIGIT_W;
  localparam int PW = SAMPLE_W + CP;
  localparam int AW = PW + $clog2(TAPS) + 1;
  localparam int QW = AW - (COEF_WIDTH - 1);
  localparam int IW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int DW = (ND > 1) ? $clog2(ND) : 1;
  localparam int LANES = 3;

  localparam logic [IW-1:0] LAST_TAP = IW'(TAPS - 1);
  localparam logic [DW-1:0] LAST_DIG = DW'(ND - 1);
  localparam logic signed [AW-1:0] BIAS = AW'((64'sd1 <<< (COEF_WIDTH - 1)) - 64'sd1);
  localparam logic signed [QW-1:0] QMAX = QW'(32767);
  localparam logic signed [QW-1:0] QMIN = QW'(-32768);

  fir_state_t state_r, state_nxt;

  logic in_accept;
  logic out_load;

  logic [TAPS-1:0] valid_r;
  logic [IW-1:0]   head_r, head_nxt;
  logic [IW-1:0]   raddr_r, raddr_nxt;
  logic [IW-1:0]   tap_r, tap_nxt;
  logic [DW-1:0]   dig_r, dig_nxt;
  logic            done_r, done_nxt;
  logic            out_en_r;
  logic            out_valid_r;
  out_t            out_data_r, out_data_nxt;

  in_t             mem [TAPS];
  in_t             rd_r;
  logic            rd_vld_r;

  logic signed [SAMPLE_W-1:0] rd_lane [LANES];
  logic signed [SAMPLE_W-1:0] s_cur [LANES];
  logic signed [SAMPLE_W-1:0] samp_r [LANES];
  logic signed [SAMPLE_W-1:0] samp_nxt [LANES];
  logic signed [SAMPLE_W+DIGIT_W:0] pp [LANES];
  logic signed [PW-1:0] prod_r [LANES];
  logic signed [PW-1:0] prod_nxt [LANES];
  logic signed [AW-1:0] acc_r [LANES];
  logic signed [AW-1:0] acc_nxt [LANES];
  logic signed [QW-1:0] q [LANES];
  logic signed [SAMPLE_W-1:0] res [LANES];

  logic signed [COEF_MAX_W-1:0] coef_full;
  logic signed [COEF_WIDTH-1:0] coef_cw;
  logic [CP-1:0]      coef_cur;
  logic [CP-1:0]      coef_sh_r, coef_sh_nxt;
  logic [DIGIT_W-1:0] digit;
  logic signed [DIGIT_W:0] dig_s;
  logic               first_dig;
  logic               last_dig;

  assign first_dig = (dig_r == '0);
  assign last_dig  = (dig_r == LAST_DIG);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PRIME;
      ST_PRIME: state_nxt = ST_MAC;
      ST_MAC:   if (last_dig && tap_r == LAST_TAP) state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_ROUND;
      ST_ROUND: state_nxt = ST_SAT;
      ST_SAT: begin
        if (!out_en_r || !out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_SAT:  out_load = out_en_r && (!out_valid_r || !out_stall);
      default: begin
        in_stall = 1'b1;
        out_load = 1'b0;
      end
    endcase
  end

  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign rd_lane[0] = rd_r.accel_x;
  assign rd_lane[1] = rd_r.accel_y;
  assign rd_lane[2] = rd_r.accel_z;

  // coefficient digits, most significant first; only the top digit is signed
  always_comb begin
    coef_full   = coef_at(int'(tap_r), COEF_WIDTH);
    coef_cw     = coef_full[COEF_WIDTH-1:0];
    coef_cur    = first_dig ? CP'(coef_cw) : coef_sh_r;
    digit       = coef_cur[CP-1 -: DIGIT_W];
    dig_s       = $signed({first_dig & digit[DIGIT_W-1], digit});
    coef_sh_nxt = coef_cur << DIGIT_W;
  end

  // address and counter sequencing
  always_comb begin
    head_nxt  = head_r;
    raddr_nxt = raddr_r;
    tap_nxt   = tap_r;
    dig_nxt   = dig_r;
    done_nxt  = 1'b0;
    if (in_accept) begin
      head_nxt  = (head_r == LAST_TAP) ? '0 : head_r + 1'b1;
      raddr_nxt = head_r;
    end
    case (state_r)
      ST_PRIME: begin
        raddr_nxt = (raddr_r == '0) ? LAST_TAP : raddr_r - 1'b1;
        tap_nxt   = '0;
        dig_nxt   = '0;
      end
      ST_MAC: begin
        done_nxt = last_dig;
        if (last_dig) begin
          raddr_nxt = (raddr_r == '0) ? LAST_TAP : raddr_r - 1'b1;
          dig_nxt   = '0;
          if (tap_r != LAST_TAP) tap_nxt = tap_r + 1'b1;
        end else begin
          dig_nxt = dig_r + 1'b1;
        end
      end
      default: begin
        done_nxt = 1'b0;
      end
    endcase
  end

  // per-axis lanes
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      s_cur[l]    = first_dig ? (rd_vld_r ? rd_lane[l] : '0) : samp_r[l];
      samp_nxt[l] = s_cur[l];
      pp[l]       = s_cur[l] * dig_s;
      prod_nxt[l] = first_dig ? PW'(pp[l]) : PW'(prod_r[l] <<< DIGIT_W) + PW'(pp[l]);
      acc_nxt[l]  = acc_r[l];
      q[l]        = QW'(acc_r[l] >>> (COEF_WIDTH - 1));
      if (q[l] > QMAX) begin
        res[l] = 16'sh7FFF;
      end else if (q[l] < QMIN) begin
        res[l] = -16'sh8000;
      end else begin
        res[l] = q[l][SAMPLE_W-1:0];
      end
      case (state_r)
        ST_PRIME: acc_nxt[l] = '0;
        ST_MAC, ST_ACC: begin
          if (done_r) acc_nxt[l] = acc_r[l] + AW'(prod_r[l]);
        end
        ST_ROUND: begin
          // bias negative sums so the shift truncates toward zero
          if (acc_r[l][AW-1]) acc_nxt[l] = acc_r[l] + BIAS;
        end
        default: acc_nxt[l] = acc_r[l];
      endcase
    end
    out_data_nxt.filtered_x = res[0];
    out_data_nxt.filtered_y = res[1];
    out_data_nxt.filtered_z = res[2];
  end

  // history memory
  always_ff @(posedge clk) begin
    if (in_accept) mem[head_r] <= in_data;
    rd_r <= mem[raddr_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    raddr_r <= raddr_nxt;
    if (state_r == ST_MAC) begin
      coef_sh_r <= coef_sh_nxt;
      for (int l = 0; l < LANES; l++) begin
        samp_r[l] <= samp_nxt[l];
        prod_r[l] <= prod_nxt[l];
      end
    end
    for (int l = 0; l < LANES; l++) begin
      acc_r[l] <= acc_nxt[l];
    end
    if (out_load) out_data_r <= out_data_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      head_r      <= '0;
      tap_r       <= '0;
      dig_r       <= '0;
      done_r      <= 1'b0;
      rd_vld_r    <= 1'b0;
      out_en_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      head_r   <= head_nxt;
      tap_r    <= tap_nxt;
      dig_r    <= dig_nxt;
      done_r   <= done_nxt;
      rd_vld_r <= valid_r[raddr_r];
      if (in_accept) valid_r[head_r] <= 1'b1;
      if (cfg_valid && cfg_ready) out_en_r <= cfg_data;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  `TAFIR_ASSERT(a_accept_starts_run, in_accept |=> state_r == ST_PRIME)
  `TAFIR_ASSERT(a_result_from_sat, $rose(out_valid_r) |-> $past(state_r == ST_SAT))
  `TAFIR_NEVER(a_tap_in_range, state_r == ST_MAC && tap_r > LAST_TAP)

endmodule

[bench/fir_lowpass_checker.sv]
module fir_lowpass_checker
  import tafir_pkg::*;
#(
  parameter int TAPS       = 201,
  parameter int COEF_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_stall,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_stall,
  input  out_t out_data,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic cfg_data,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PROTO_LEN  = 201;
  localparam int PROTO_HALF = 101;
  localparam int MAX_PRINTED = 100;

  // q1.15 prototype, outer tap first, center tap last
  localparam int PROTO_COEF [PROTO_HALF] = '{
    -2, -7, -8, -5, 1, 7, 10, 7, 0, -8,
    -12, -9, -1, 8, 15, 13, 4, -9, -18, -19,
    -8, 8, 22, 25, 14, -7, -26, -33, -22, 3,
    30, 42, 32, 2, -33, -53, -45, -11, 33, 64,
    61, 23, -32, -74, -79, -39, 27, 84, 100, 60,
    -17, -93, -123, -87, 2, 98, 148, 119, 20, -100,
    -175, -158, -50, 96, 202, 204, 91, -84, -229, -258,
    -144, 63, 255, 323, 214, -28, -280, -402, -308, -27,
    303, 501, 438, 114, -322, -637, -631, -256, 338, 848,
    960, 521, -350, -1262, -1689, -1194, 357, 2695, 5202, 7120,
    7838
  };

  logic signed [15:0] delay_line [3][TAPS];
  logic               out_enable;
  out_t               expected_filtered [$];
  int                 mismatches = 0;

  function automatic longint tap_weight(int k);
    int c;
    int s;
    if (k >= PROTO_LEN) return 0;
    c = PROTO_COEF[(k < PROTO_HALF) ? k : (PROTO_LEN - 1 - k)];
    if (COEF_WIDTH >= 16) return longint'(c) <<< (COEF_WIDTH - 16);
    s = 16 - COEF_WIDTH;
    // round half up
    return longint'((c + (1 <<< (s - 1))) >>> s);
  endfunction

  // shift one sample into an axis and return its filtered value
  function automatic logic signed [15:0] lowpass_axis(int axis, logic signed [15:0] sample);
    longint acc;
    longint q;
    int k;
    for (k = TAPS - 1; k > 0; k--) delay_line[axis][k] = delay_line[axis][k-1];
    delay_line[axis][0] = sample;
    acc = 0;
    for (k = 0; k < TAPS; k++) acc += longint'(delay_line[axis][k]) * tap_weight(k);
    q = acc / (longint'(1) <<< (COEF_WIDTH - 1));
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic report(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin
    out_t want;
    int a;
    int k;
    if (!rst_n) begin
      for (a = 0; a < 3; a++)
        for (k = 0; k < TAPS; k++) delay_line[a][k] = '0;
      out_enable = 1'b0;
      expected_filtered.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_filtered.size() == 0) begin
          report($sformatf("result with nothing expected: x=%0d y=%0d z=%0d",
                           out_data.filtered_x, out_data.filtered_y, out_data.filtered_z));
        end else begin
          want = expected_filtered.pop_front();
          if (out_data.filtered_x !== want.filtered_x)
            report($sformatf("filtered_x got %0d want %0d", out_data.filtered_x,
                             want.filtered_x));
          if (out_data.filtered_y !== want.filtered_y)
            report($sformatf("filtered_y got %0d want %0d", out_data.filtered_y,
                             want.filtered_y));
          if (out_data.filtered_z !== want.filtered_z)
            report($sformatf("filtered_z got %0d want %0d", out_data.filtered_z,
                             want.filtered_z));
        end
      end
      if (cfg_valid && cfg_ready) out_enable = cfg_data;
      if (in_valid && !in_stall) begin
        want.filtered_x = lowpass_axis(0, in_data.accel_x);
        want.filtered_y = lowpass_axis(1, in_data.accel_y);
        want.filtered_z = lowpass_axis(2, in_data.accel_z);
        // history moves on even when nothing is let out
        if (out_enable) expected_filtered.push_back(want);
      end
    end
    pending    <= expected_filtered.size();
    fail_count <= mismatches;
  end

endmodule

[bench/tb_three_axis_fir_lowpass_core.sv]
module tb_three_axis_fir_lowpass_core;
  timeunit 1ns;
  timeprecision 1ps;
  import tafir_pkg::*;

  localparam int FIR_TAPS      = 201;
  localparam int FIR_CW        = 16;
  localparam int TOTAL_WORDS   = 930;
  localparam int QUIET_TAIL    = 120;
  localparam int HOLD_AT       = 480;
  localparam int HOLD_CYCLES   = 3000;
  localparam int SETTLE_CYCLES = FIR_TAPS * ((FIR_CW + 7) / 8) + 40;
  localparam logic signed [15:0] S_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S_MIN = 16'sh8000;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data  = 1'b0;
  int   fail_count;
  int   pending;

  bit   idle_on       = 1'b1;
  bit   stall_on      = 1'b1;
  int   hold_requests = 0;
  int   words_sent    = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  three_axis_fir_lowpass_core #(
    .TAPS       (FIR_TAPS),
    .COEF_WIDTH (FIR_CW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  fir_lowpass_checker #(
    .TAPS       (FIR_TAPS),
    .COEF_WIDTH (FIR_CW)
  ) chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  task automatic offer(input logic signed [15:0] ax, ay, az);
    if (words_sent >= TOTAL_WORDS - QUIET_TAIL) begin
      idle_on = 1'b0;
      stall_on <= 1'b0;
    end
    if (idle_on) begin
      if ($urandom_range(0, 2) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= '{accel_x: ax, accel_y: ay, accel_z: az};
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (words_sent == HOLD_AT) hold_requests <= hold_requests + 1;
  endtask

  // drain the filter before touching the enable bit
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_enable(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_level();
    case ($urandom_range(0, 3))
      0:       return S_MAX;
      1:       return S_MIN;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int drift(int v);
    int n;
    n = v + int'($urandom_range(0, 4000)) - 2000;
    if (n > 32767) n = 32767;
    if (n < -32768) n = -32768;
    return n;
  endfunction

  task automatic run_segment();
    int kind;
    int len;
    int k;
    int wx, wy, wz;
    logic signed [15:0] lx, ly, lz;
    if (words_sent < TOTAL_WORDS - QUIET_TAIL) begin
      idle_on = ($urandom_range(0, 3) != 0);
      stall_on <= ($urandom_range(0, 3) != 0);
    end
    kind = $urandom_range(0, 9);
    if (kind < 4) begin
      len = $urandom_range(10, 50);
      for (k = 0; k < len && words_sent < TOTAL_WORDS; k++)
        offer(16'($urandom), 16'($urandom), 16'($urandom));
    end else if (kind < 7) begin
      // long steps push the filter into its overshoot and saturate
      len = $urandom_range(100, 160);
      lx = pick_level();
      ly = pick_level();
      lz = pick_level();
      for (k = 0; k < len && words_sent < TOTAL_WORDS; k++) offer(lx, ly, lz);
    end else begin
      len = $urandom_range(30, 80);
      wx = int'($urandom_range(0, 65535)) - 32768;
      wy = int'($urandom_range(0, 65535)) - 32768;
      wz = int'($urandom_range(0, 65535)) - 32768;
      for (k = 0; k < len && words_sent < TOTAL_WORDS; k++) begin
        wx = drift(wx);
        wy = drift(wy);
        wz = drift(wz);
        offer(16'(wx), 16'(wy), 16'(wz));
      end
    end
  endtask

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    int served;
    served = 0;
    @(posedge clk);
    forever begin
      if (hold_requests != served) begin
        served = hold_requests;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    logic signed [15:0] corner [8];
    int i;
    corner = '{S_MAX, S_MIN, 16'sh0000, 16'shFFFF, 16'sh0001, 16'sh5555, 16'shAAAA,
               16'sh00FF};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // enable still at its reset value: words only fill the history
    for (i = 0; i < 6; i++) offer(16'($urandom), 16'($urandom), 16'($urandom));
    settle();
    write_enable(1'b1);

    for (i = 0; i < 8; i++) offer(corner[i], corner[7-i], corner[(i + 3) % 8]);
    for (i = 0; i < 6; i++) begin
      if (i % 2 == 0) offer(S_MAX, S_MIN, S_MAX);
      else offer(S_MIN, S_MAX, 16'sh0000);
    end
    // full-scale step in opposite directions drives both rails
    for (i = 0; i < 130; i++) offer(S_MAX, S_MIN, S_MAX);

    settle();
    write_enable(1'b0);
    for (i = 0; i < 60; i++) offer(16'($urandom), 16'($urandom), 16'($urandom));
    settle();
    write_enable(1'b1);

    while (words_sent < TOTAL_WORDS) run_segment();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/tafir_pkg.sv
sv/three_axis_fir_lowpass_core.sv
bench/fir_lowpass_checker.sv
bench/tb_three_axis_fir_lowpass_core.sv
